[hdl/ppm_pkg.sv]
package ppm_pkg;

	localparam int unsigned SAMPLE_W       = 16;
	localparam int unsigned TIMEOUT_W      = 8;
	localparam int unsigned CFG_INDEX_W    = 8;
	localparam int unsigned CFG_DATA_W     = 16;
	localparam int unsigned IN_TDATA_W     = 40;
	localparam int unsigned OUT_TDATA_W    = 8;
	localparam int unsigned MISS_COUNT_W_DEFAULT = 8;

	// register indexes on the configuration channel
	localparam logic [CFG_INDEX_W-1:0] REG_OVER_POWER_LIMIT      = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_UNDER_VOLTAGE_TRIP    = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_UNDER_VOLTAGE_RECOVER = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LINK_TIMEOUT          = 8'd3;

	// reset values: 240.0 W, 18.0 V, 20.0 V, 40 ticks
	localparam logic [SAMPLE_W-1:0]  OVER_POWER_LIMIT_RST      = 16'd2400;
	localparam logic [SAMPLE_W-1:0]  UNDER_VOLTAGE_TRIP_RST    = 16'd18000;
	localparam logic [SAMPLE_W-1:0]  UNDER_VOLTAGE_RECOVER_RST = 16'd20000;
	localparam logic [TIMEOUT_W-1:0] LINK_TIMEOUT_RST          = 8'd40;

	typedef enum logic [1:0] {
		STATUS_OK            = 2'd0,
		STATUS_OVER_POWER    = 2'd1,
		STATUS_UNDER_VOLTAGE = 2'd2,
		STATUS_LINK_ERROR    = 2'd3
	} ppm_status_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]  over_power_limit;
		logic [SAMPLE_W-1:0]  under_voltage_trip;
		logic [SAMPLE_W-1:0]  under_voltage_recover;
		logic [TIMEOUT_W-1:0] link_timeout;
	} ppm_cfg_t;

	typedef struct packed {
		logic                host_link_ok;
		logic                referee_link_ok;
		logic [SAMPLE_W-1:0] battery_voltage_sample;
		logic [SAMPLE_W-1:0] chassis_power_sample;
	} ppm_sample_t;

	typedef struct packed {
		logic        host_rx_rearm;
		logic        buffer_override;
		logic        referee_rx_rearm;
		logic        restart_request;
		logic        all_off_request;
		ppm_status_t status_code;
	} ppm_result_t;

endpackage

[hdl/power_protection_monitor.sv]
// Power protection monitor. One word in per sample tick, one status word out
// for each. Throughput is one word per clock while m_tready takes the output;
// a word passes from s_* through an input register, then the trip/link logic
// feeding the result register, on its way to m_*. Over-power and under-voltage
// are each confirmed on two consecutive samples, then latch until arst_n and
// raise all_off_request for the confirming sample only. While under-voltage
// is latched, every sample at or above the recovery level raises
// restart_request. The referee miss counter (MISS_COUNT_WIDTH bits,
// saturating) flags a link error once it reaches link_timeout; a good tick
// clears it. status_code priority: over power, under voltage, link error.
// Configuration writes are always accepted and must be made while idle.
module power_protection_monitor #(
	parameter int unsigned MISS_COUNT_WIDTH = ppm_pkg::MISS_COUNT_W_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [15:0] chassis_power_sample, [31:16] battery_voltage_sample,
	// [32] referee_link_ok, [33] host_link_ok, [39:34] zero
	input  logic [ppm_pkg::IN_TDATA_W-1:0]  s_tdata,
	// status stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] status_code, [2] all_off_request, [3] restart_request,
	// [4] referee_rx_rearm, [5] buffer_override, [6] host_rx_rearm, [7] zero
	output logic [ppm_pkg::OUT_TDATA_W-1:0] m_tdata,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ppm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ppm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ppm_pkg::*;

	ppm_cfg_t    cfg;
	ppm_sample_t sample_s1;
	logic        valid_s1;
	ppm_result_t result;
	ppm_result_t result_s2;
	logic        valid_s2;
	logic        load_s2;    // s1 word moves to s2, state steps
	logic        free_s2;

	assign free_s2  = !valid_s2 || m_tready;
	assign load_s2  = valid_s1 && free_s2;
	assign s_tready = !valid_s1 || free_s2;
	assign cfg_ready = 1'b1;

	ppm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= ppm_sample_t'(s_tdata[SAMPLE_W*2+1:0]);
		end
	end

	ppm_core #(
		.MISS_COUNT_WIDTH (MISS_COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load_s2),
		.cfg    (cfg),
		.sample (sample_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, result_s2};

	// a trip pulse only ever comes with a latched trip status
	a_all_off_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.all_off_request |->
			result_s2.status_code == STATUS_OVER_POWER ||
			result_s2.status_code == STATUS_UNDER_VOLTAGE)
		else $error("all_off_request without a trip status");

	// restart needs latched undervoltage, shown unless over power outranks it
	a_restart_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.restart_request |->
			result_s2.status_code == STATUS_UNDER_VOLTAGE ||
			result_s2.status_code == STATUS_OVER_POWER)
		else $error("restart_request without latched undervoltage");

	// an empty result register never holds back the input side
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a stepped word always reaches the result register in the next cycle
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> m_tvalid)
		else $error("stepped word lost");

endmodule

[hdl/ppm_cfg.sv]
module ppm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [ppm_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [ppm_pkg::CFG_DATA_W-1:0]  wr_data,
	output ppm_pkg::ppm_cfg_t               cfg
);
	import ppm_pkg::*;

	ppm_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.over_power_limit      <= OVER_POWER_LIMIT_RST;
			cfg_q.under_voltage_trip    <= UNDER_VOLTAGE_TRIP_RST;
			cfg_q.under_voltage_recover <= UNDER_VOLTAGE_RECOVER_RST;
			cfg_q.link_timeout          <= LINK_TIMEOUT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_OVER_POWER_LIMIT:      cfg_q.over_power_limit      <= wr_data;
				REG_UNDER_VOLTAGE_TRIP:    cfg_q.under_voltage_trip    <= wr_data;
				REG_UNDER_VOLTAGE_RECOVER: cfg_q.under_voltage_recover <= wr_data;
				REG_LINK_TIMEOUT:          cfg_q.link_timeout <= wr_data[TIMEOUT_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/ppm_core.sv]
module ppm_core #(
	parameter int unsigned MISS_COUNT_WIDTH = ppm_pkg::MISS_COUNT_W_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  ppm_pkg::ppm_cfg_t    cfg,
	input  ppm_pkg::ppm_sample_t sample,
	output ppm_pkg::ppm_result_t result
);
	import ppm_pkg::*;

	// common width for the timeout compare
	localparam int unsigned CMP_W =
		(MISS_COUNT_WIDTH > TIMEOUT_W) ? MISS_COUNT_WIDTH : TIMEOUT_W;

	logic                        op_latched_q, op_pending_q;
	logic                        uv_latched_q, uv_pending_q;
	logic [MISS_COUNT_WIDTH-1:0] miss_cnt_q;
	logic                        link_err_q;

	logic                        op_latched_d, op_pending_d;
	logic                        uv_latched_d, uv_pending_d;
	logic [MISS_COUNT_WIDTH-1:0] miss_cnt_d;
	logic                        link_err_d;
	logic                        op_exceed, uv_low, uv_recovered;
	logic                        op_trip, uv_trip;
	logic [CMP_W-1:0]            cnt_ext, timeout_ext;

	assign op_exceed    = sample.chassis_power_sample > cfg.over_power_limit;
	assign uv_low       = sample.battery_voltage_sample < cfg.under_voltage_trip;
	assign uv_recovered = sample.battery_voltage_sample >= cfg.under_voltage_recover;

	assign op_trip = !op_latched_q && op_exceed && op_pending_q;
	assign uv_trip = !uv_latched_q && uv_low && uv_pending_q;

	always_comb begin
		op_latched_d = op_latched_q | op_trip;
		op_pending_d = op_latched_q ? op_pending_q : (op_exceed && !op_pending_q);
		uv_latched_d = uv_latched_q | uv_trip;
		uv_pending_d = uv_low && !uv_latched_q && !uv_pending_q;
	end

	// saturating miss count, cleared by a good tick
	always_comb begin
		if (sample.referee_link_ok) begin
			miss_cnt_d = '0;
		end else if (&miss_cnt_q) begin
			miss_cnt_d = miss_cnt_q;
		end else begin
			miss_cnt_d = miss_cnt_q + 1'b1;
		end
		cnt_ext     = CMP_W'(miss_cnt_d);
		timeout_ext = CMP_W'(cfg.link_timeout);
		link_err_d  = !sample.referee_link_ok && (link_err_q || cnt_ext >= timeout_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_latched_q <= 1'b0;
			op_pending_q <= 1'b0;
			uv_latched_q <= 1'b0;
			uv_pending_q <= 1'b0;
			miss_cnt_q   <= '0;
			link_err_q   <= 1'b0;
		end else if (step) begin
			op_latched_q <= op_latched_d;
			op_pending_q <= op_pending_d;
			uv_latched_q <= uv_latched_d;
			uv_pending_q <= uv_pending_d;
			miss_cnt_q   <= miss_cnt_d;
			link_err_q   <= link_err_d;
		end
	end

	always_comb begin
		if (op_latched_d) begin
			result.status_code = STATUS_OVER_POWER;
		end else if (uv_latched_d) begin
			result.status_code = STATUS_UNDER_VOLTAGE;
		end else if (link_err_d) begin
			result.status_code = STATUS_LINK_ERROR;
		end else begin
			result.status_code = STATUS_OK;
		end
		result.all_off_request  = op_trip | uv_trip;
		result.restart_request  = uv_latched_q && uv_recovered;
		result.referee_rx_rearm = !sample.referee_link_ok;
		result.buffer_override  = !sample.referee_link_ok;
		result.host_rx_rearm    = !sample.host_link_ok;
	end

endmodule
